FILE: design/spq_pkg.sv
// Shared definitions for the stable priority queue unit.
// Holds default sizes, command and status codes and the cell select type.
// No dependencies.
package spq_pkg;

  localparam int DEF_CAPACITY       = 16;
  localparam int DEF_VALUE_WIDTH    = 16;
  localparam int DEF_PRIORITY_WIDTH = 8;

  localparam int CMD_WIDTH    = 2;
  localparam int STATUS_WIDTH = 2;

  localparam logic [CMD_WIDTH-1:0] CMD_NOP     = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_ENQUEUE = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_DEQUEUE = 2'd2;

  localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd2;

  // Where a cell takes its next contents from.
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_NEW,
    SEL_LEFT,
    SEL_RIGHT
  } cell_sel_t;

endpackage

FILE: design/spq_cell.sv
// One slot of the sorted queue chain: an entry register, its next-value
// mux and the priority compare against the incoming entry.
// Depends on spq_pkg.
module spq_cell #(
  parameter int VALUE_WIDTH    = spq_pkg::DEF_VALUE_WIDTH,
  parameter int PRIORITY_WIDTH = spq_pkg::DEF_PRIORITY_WIDTH
) (
  input  logic                      clk,
  input  spq_pkg::cell_sel_t        sel,
  input  logic [VALUE_WIDTH-1:0]    new_value,
  input  logic [PRIORITY_WIDTH-1:0] new_priority,
  input  logic [VALUE_WIDTH-1:0]    left_value,
  input  logic [PRIORITY_WIDTH-1:0] left_priority,
  input  logic [VALUE_WIDTH-1:0]    right_value,
  input  logic [PRIORITY_WIDTH-1:0] right_priority,
  output logic [VALUE_WIDTH-1:0]    value_r,
  output logic [PRIORITY_WIDTH-1:0] priority_r,
  output logic [VALUE_WIDTH-1:0]    value_nxt,
  output logic [PRIORITY_WIDTH-1:0] priority_nxt,
  output logic                      above_new
);

  // A stored entry with equal priority stays ahead of the new one.
  assign above_new = priority_r > new_priority;

  always_comb begin
    case (sel)
      spq_pkg::SEL_NEW: begin
        value_nxt    = new_value;
        priority_nxt = new_priority;
      end
      spq_pkg::SEL_LEFT: begin
        value_nxt    = left_value;
        priority_nxt = left_priority;
      end
      spq_pkg::SEL_RIGHT: begin
        value_nxt    = right_value;
        priority_nxt = right_priority;
      end
      default: begin
        value_nxt    = value_r;
        priority_nxt = priority_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    priority_r <= priority_nxt;
  end

endmodule

FILE: design/stable_priority_queue_unit.sv
// Top level of the stable priority queue: a chain of cells plus the fill
// count, the per-cell control and the registered result word.
// Depends on spq_pkg and spq_cell.
//
// The queue keeps up to CAPACITY entries sorted by priority in a row of
// cells, lowest priority number in cell 0. Entries of equal priority leave in
// arrival order. Every input word carries a command in in_tuser (nop, enqueue
// or dequeue of the front entry) and produces exactly one result word that
// describes the queue after the command: front entry, empty flag, entry count
// and a status. An enqueue on a full queue is refused with status full and a
// dequeue on an empty queue is ignored with status empty; command code 3 acts
// as a nop. For each accepted word all cells compare their priority with
// the incoming one in parallel and either load the new entry, shift one place
// toward the back, shift one place toward the front or hold. The result is
// registered and appears the cycle after the input word is accepted. A new
// word is accepted whenever the result register is empty or its word is
// being taken in the same cycle, so one word per cycle is sustained while the
// output side keeps out_tready high. Cells beyond the fill count hold stale
// data and are never shown; there is no clearing pass after reset.
module stable_priority_queue_unit #(
  parameter int CAPACITY       = spq_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH    = spq_pkg::DEF_VALUE_WIDTH,
  parameter int PRIORITY_WIDTH = spq_pkg::DEF_PRIORITY_WIDTH,
  localparam int CW     = $clog2(CAPACITY + 1),
  localparam int IN_DW  = ((VALUE_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((VALUE_WIDTH + PRIORITY_WIDTH + 1 + CW + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: item_value, item_priority, zero fill.
  input  logic [IN_DW-1:0]                 in_tdata,
  // Fields from bit 0: command.
  input  logic [spq_pkg::CMD_WIDTH-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // Fields from bit 0: front_value, front_priority, queue_empty,
  // entry_count, zero fill.
  output logic [OUT_DW-1:0]                out_tdata,
  // Fields from bit 0: status.
  output logic [spq_pkg::STATUS_WIDTH-1:0] out_tuser
);

  localparam int PAD = OUT_DW - (VALUE_WIDTH + PRIORITY_WIDTH + 1 + CW);

  logic                      in_fire;
  logic [VALUE_WIDTH-1:0]    new_value;
  logic [PRIORITY_WIDTH-1:0] new_priority;
  logic [spq_pkg::CMD_WIDTH-1:0] cmd;

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0] out_data_r, out_data_nxt;
  logic [spq_pkg::STATUS_WIDTH-1:0] out_status_r, out_status_nxt;
  logic [spq_pkg::STATUS_WIDTH-1:0] status;

  logic do_enqueue, do_dequeue, is_full, is_empty;

  logic [VALUE_WIDTH-1:0]    cell_value   [CAPACITY];
  logic [PRIORITY_WIDTH-1:0] cell_priority[CAPACITY];
  logic [VALUE_WIDTH-1:0]    cell_value_nxt   [CAPACITY];
  logic [PRIORITY_WIDTH-1:0] cell_priority_nxt[CAPACITY];
  logic [CAPACITY-1:0]       above;
  logic [CAPACITY-1:0]       occupied;
  spq_pkg::cell_sel_t        sel [CAPACITY];

  logic [VALUE_WIDTH-1:0]    front_value;
  logic [PRIORITY_WIDTH-1:0] front_priority;
  logic                      queue_empty;

  assign in_tready    = !out_valid_r || out_tready;
  assign in_fire      = in_tvalid && in_tready;
  assign new_value    = in_tdata[VALUE_WIDTH-1:0];
  assign new_priority = in_tdata[VALUE_WIDTH +: PRIORITY_WIDTH];
  assign cmd          = in_tuser;

  assign is_full    = count_r == CW'(CAPACITY);
  assign is_empty   = count_r == '0;
  assign do_enqueue = in_fire && (cmd == spq_pkg::CMD_ENQUEUE) && !is_full;
  assign do_dequeue = in_fire && (cmd == spq_pkg::CMD_DEQUEUE) && !is_empty;

  always_comb begin
    if (cmd == spq_pkg::CMD_ENQUEUE && is_full) begin
      status = spq_pkg::ST_FULL;
    end else if (cmd == spq_pkg::CMD_DEQUEUE && is_empty) begin
      status = spq_pkg::ST_EMPTY;
    end else begin
      status = spq_pkg::ST_OK;
    end
  end

  // Per-cell control. Stored priorities are sorted, so the cells above the
  // new priority form one run at the back of the occupied part; the new
  // entry lands at the first cell that is above it or not occupied.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occupied[i] = CW'(i) < count_r;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      sel[i] = spq_pkg::SEL_HOLD;
      if (do_enqueue) begin
        if (i == 0) begin
          if (above[i] || !occupied[i]) sel[i] = spq_pkg::SEL_NEW;
        end else if (occupied[i-1] && above[i-1]) begin
          sel[i] = spq_pkg::SEL_LEFT;
        end else if (occupied[i-1] && (above[i] || !occupied[i])) begin
          sel[i] = spq_pkg::SEL_NEW;
        end
      end else if (do_dequeue) begin
        sel[i] = spq_pkg::SEL_RIGHT;
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0]    lv, rv;
    logic [PRIORITY_WIDTH-1:0] lp, rp;
    if (g == 0) begin : g_first
      assign lv = cell_value[g];
      assign lp = cell_priority[g];
    end else begin : g_mid_l
      assign lv = cell_value[g-1];
      assign lp = cell_priority[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign rv = cell_value[g];
      assign rp = cell_priority[g];
    end else begin : g_mid_r
      assign rv = cell_value[g+1];
      assign rp = cell_priority[g+1];
    end
    spq_cell #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .PRIORITY_WIDTH(PRIORITY_WIDTH)
    ) u_cell (
      .clk           (clk),
      .sel           (sel[g]),
      .new_value     (new_value),
      .new_priority  (new_priority),
      .left_value    (lv),
      .left_priority (lp),
      .right_value   (rv),
      .right_priority(rp),
      .value_r       (cell_value[g]),
      .priority_r    (cell_priority[g]),
      .value_nxt     (cell_value_nxt[g]),
      .priority_nxt  (cell_priority_nxt[g]),
      .above_new     (above[g])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (do_enqueue) begin
      count_nxt = count_r + CW'(1);
    end else if (do_dequeue) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // The result describes the queue after the command, so it is built from
  // the count and front cell as they will be after this edge.
  assign queue_empty    = count_nxt == '0;
  assign front_value    = queue_empty ? '0 : cell_value_nxt[0];
  assign front_priority = queue_empty ? '0 : cell_priority_nxt[0];

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = {{PAD{1'b0}}, count_nxt, queue_empty, front_priority, front_value};
      out_status_nxt = status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule
